[sv/cc3_pkg.sv]
// Shared types, constants and helper functions of the 3x3 convolution stream.
package cc3_pkg;

	localparam int PIX_W     = 8;
	localparam int COEF_BITS = 16;
	localparam int FRAC_BITS = 8;
	localparam int KROW_W    = 48;
	localparam int CFG_IDX_W = 3;
	localparam int GEOM_W    = 12;
	localparam int ROW_W     = GEOM_W + 1;
	localparam int PROD_W    = PIX_W + COEF_BITS + 1;
	localparam int RSUM_W    = PROD_W + 2;
	localparam int ACC_W     = PROD_W + 4;

	typedef logic [CFG_IDX_W-1:0]          cfg_idx_t;
	typedef logic [PIX_W-1:0]              pix_t;
	typedef logic [KROW_W-1:0]             krow_t;
	typedef logic [GEOM_W-1:0]             geom_t;
	typedef logic signed [COEF_BITS-1:0]   coef_t;
	typedef logic signed [PROD_W-1:0]      prod_t;
	typedef logic signed [RSUM_W-1:0]      rsum_t;
	typedef logic signed [ACC_W-1:0]       acc_t;
	typedef logic [2:0][2:0][PIX_W-1:0]    win_t;

	typedef struct packed {
		logic interior;
		logic last;
	} out_tag_t;

	localparam cfg_idx_t REG_IMAGE_WIDTH   = cfg_idx_t'(0);
	localparam cfg_idx_t REG_IMAGE_HEIGHT  = cfg_idx_t'(1);
	localparam cfg_idx_t REG_KERNEL_TOP    = cfg_idx_t'(2);
	localparam cfg_idx_t REG_KERNEL_MIDDLE = cfg_idx_t'(3);
	localparam cfg_idx_t REG_KERNEL_BOTTOM = cfg_idx_t'(4);

	localparam logic CMD_FLUSH = 1'b1;

	localparam krow_t KROW_OUTER_RST  = 48'h0100_0000_FF00;
	localparam krow_t KROW_MIDDLE_RST = 48'h0200_0000_FE00;

	localparam geom_t WIDTH_RST  = geom_t'(640);
	localparam geom_t HEIGHT_RST = geom_t'(480);
	localparam geom_t GEOM_MIN   = geom_t'(3);

	// Negative sums give zero; otherwise drop the fraction and saturate.
	function automatic pix_t clamp_acc(acc_t a);
		pix_t r;
		if (a[ACC_W-1]) begin
			r = '0;
		end else if (|a[ACC_W-2:FRAC_BITS+PIX_W]) begin
			r = '1;
		end else begin
			r = a[FRAC_BITS +: PIX_W];
		end
		return r;
	endfunction

endpackage

[sv/conv3x3_clamp_stream.sv]
// Top level: frame position counters, configuration registers and the first pipeline stage.
// Throughput is one item per clock; the input stalls only while the output is stalled and
// every pipeline stage ahead holds an item.
// A result moves via the stage-one, product and row-sum registers into the output register.
// In image terms an output lags its input by one row plus one pixel.
// Reset clears the counters and pipeline, loads the Sobel X kernel and 640x480 geometry,
// and leaves the line store contents unknown.
module conv3x3_clamp_stream #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              cmd,
	input  cc3_pkg::pix_t     pixel_in,
	output logic              out_valid,
	input  logic              out_stall,
	output cc3_pkg::pix_t     pixel_out,
	output logic              frame_end,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  cc3_pkg::cfg_idx_t cfg_index,
	input  cc3_pkg::krow_t    cfg_data
);
	import cc3_pkg::*;

	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int XW = ((CW > GEOM_W) ? CW : GEOM_W) + 1;

	function automatic geom_t sat_width(geom_t v);
		geom_t r;
		if (v < GEOM_MIN) begin
			r = GEOM_MIN;
		end else if (32'(v) > MAX_WIDTH) begin
			r = GEOM_W'(MAX_WIDTH);
		end else begin
			r = v;
		end
		return r;
	endfunction

	geom_t            width_q;
	geom_t            height_q;
	krow_t [2:0]      kernel_q;
	logic [CW-1:0]    in_col_q;
	logic [ROW_W-1:0] in_row_q;
	logic [CW-1:0]    out_col_q;
	geom_t            out_row_q;

	logic             v_s1;
	pix_t             px_s1;
	logic [CW-1:0]    col_s1;
	logic             emit_s1;
	out_tag_t         tag_s1;

	logic             cfg_we;
	logic             accept;
	logic             drain;
	logic             push;
	logic             emit;
	logic             col_wrap;
	logic             ocol_end;
	out_tag_t         tag;
	logic             s1_adv;
	logic             win_ready;
	logic             sum_take;
	pix_t             up;
	pix_t             lo;
	logic             valid_s2;
	prod_t [2:0][2:0] prod_s2;
	pix_t             center_s2;
	out_tag_t         tag_s2;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;
	assign accept    = in_valid && !in_stall;

	assign drain = in_row_q >= ROW_W'(height_q);
	assign push  = drain || (cmd != CMD_FLUSH);
	assign emit  = drain || ((cmd != CMD_FLUSH)
		&& ((in_row_q >= ROW_W'(2)) || ((in_row_q == ROW_W'(1)) && (in_col_q != '0))));

	assign col_wrap = (XW'(in_col_q) + XW'(1)) >= XW'(width_q);
	assign ocol_end = (XW'(out_col_q) + XW'(1)) == XW'(width_q);

	assign tag.interior = (out_row_q != '0)
		&& ((ROW_W'(out_row_q) + ROW_W'(2)) <= ROW_W'(height_q))
		&& (out_col_q != '0)
		&& ((XW'(out_col_q) + XW'(2)) <= XW'(width_q));
	assign tag.last = ocol_end && ((ROW_W'(out_row_q) + ROW_W'(1)) == ROW_W'(height_q));

	assign s1_adv   = v_s1 && (!emit_s1 || win_ready);
	assign in_stall = v_s1 && !s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= sat_width(WIDTH_RST);
			height_q <= HEIGHT_RST;
			kernel_q <= {KROW_OUTER_RST, KROW_MIDDLE_RST, KROW_OUTER_RST};
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH: begin
					width_q <= sat_width(cfg_data[GEOM_W-1:0]);
				end
				REG_IMAGE_HEIGHT: begin
					height_q <= (cfg_data[GEOM_W-1:0] < GEOM_MIN) ? GEOM_MIN
						: cfg_data[GEOM_W-1:0];
				end
				REG_KERNEL_TOP: begin
					kernel_q[0] <= cfg_data;
				end
				REG_KERNEL_MIDDLE: begin
					kernel_q[1] <= cfg_data;
				end
				REG_KERNEL_BOTTOM: begin
					kernel_q[2] <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (cfg_we && ((cfg_index == REG_IMAGE_WIDTH)
				|| (cfg_index == REG_IMAGE_HEIGHT))) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (accept) begin
			if (emit && tag.last) begin
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end else begin
				if (push) begin
					if (col_wrap) begin
						in_col_q <= '0;
						in_row_q <= in_row_q + ROW_W'(1);
					end else begin
						in_col_q <= in_col_q + CW'(1);
					end
				end
				if (emit) begin
					if (ocol_end) begin
						out_col_q <= '0;
						out_row_q <= out_row_q + GEOM_W'(1);
					end else begin
						out_col_q <= out_col_q + CW'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept && push) begin
			v_s1 <= 1'b1;
		end else if (s1_adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && push) begin
			px_s1   <= drain ? '0 : pixel_in;
			col_s1  <= in_col_q;
			emit_s1 <= emit;
			tag_s1  <= tag;
		end
	end

	cc3_line_buf #(
		.DEPTH(MAX_WIDTH)
	) u_line_buf (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept && push),
		.rd_addr (in_col_q),
		.wr_en   (s1_adv),
		.wr_addr (col_s1),
		.wr_pix  (px_s1),
		.up      (up),
		.lo      (lo)
	);

	cc3_window u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.shift     (s1_adv),
		.emit      (emit_s1),
		.tag_s1    (tag_s1),
		.up        (up),
		.lo        (lo),
		.px        (px_s1),
		.kernel    (kernel_q),
		.take      (sum_take),
		.ready     (win_ready),
		.valid_s2  (valid_s2),
		.prod_s2   (prod_s2),
		.center_s2 (center_s2),
		.tag_s2    (tag_s2)
	);

	cc3_sum u_sum (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s2  (valid_s2),
		.prod_s2   (prod_s2),
		.center_s2 (center_s2),
		.tag_s2    (tag_s2),
		.out_stall (out_stall),
		.take      (sum_take),
		.out_valid (out_valid),
		.pixel_out (pixel_out),
		.frame_end (frame_end)
	);

endmodule

[sv/cc3_line_buf.sv]
// Two line stores held in one memory, with a bypass for a write to the address being read.
module cc3_line_buf #(
	parameter int DEPTH = 2048,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  cc3_pkg::pix_t wr_pix,
	output cc3_pkg::pix_t up,
	output cc3_pkg::pix_t lo
);
	import cc3_pkg::*;

	logic [2*PIX_W-1:0] mem [DEPTH];
	logic [2*PIX_W-1:0] mem_rd_q;
	logic [2*PIX_W-1:0] byp_data_q;
	logic               byp_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {lo, wr_pix};
		end
		if (rd_en) begin
			mem_rd_q   <= mem[rd_addr];
			byp_data_q <= {lo, wr_pix};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else if (rd_en) begin
			byp_q <= wr_en && (rd_addr == wr_addr);
		end
	end

	assign {up, lo} = byp_q ? byp_data_q : mem_rd_q;

endmodule

[sv/cc3_window.sv]
// The 3x3 pixel window and the nine coefficient products of the second stage.
module cc3_window (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      shift,
	input  logic                      emit,
	input  cc3_pkg::out_tag_t         tag_s1,
	input  cc3_pkg::pix_t             up,
	input  cc3_pkg::pix_t             lo,
	input  cc3_pkg::pix_t             px,
	input  cc3_pkg::krow_t [2:0]      kernel,
	input  logic                      take,
	output logic                      ready,
	output logic                      valid_s2,
	output cc3_pkg::prod_t [2:0][2:0] prod_s2,
	output cc3_pkg::pix_t             center_s2,
	output cc3_pkg::out_tag_t         tag_s2
);
	import cc3_pkg::*;

	win_t win_q;
	win_t win_d;
	logic v_s2;

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			win_d[r][0] = win_q[r][1];
			win_d[r][1] = win_q[r][2];
		end
		win_d[0][2] = up;
		win_d[1][2] = lo;
		win_d[2][2] = px;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
			v_s2  <= 1'b0;
		end else begin
			if (shift) begin
				win_q <= win_d;
			end
			if (shift && emit) begin
				v_s2 <= 1'b1;
			end else if (take) begin
				v_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (shift && emit) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					prod_s2[r][c] <= prod_t'($signed({1'b0, win_d[r][c]})
						* coef_t'(kernel[r][c*COEF_BITS +: COEF_BITS]));
				end
			end
			center_s2 <= win_d[1][1];
			tag_s2    <= tag_s1;
		end
	end

	assign ready    = !v_s2 || take;
	assign valid_s2 = v_s2;

endmodule

[sv/cc3_sum.sv]
// Row sums, final sum with clamping (centre pixel passed at borders), and the output register.
module cc3_sum (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      valid_s2,
	input  cc3_pkg::prod_t [2:0][2:0] prod_s2,
	input  cc3_pkg::pix_t             center_s2,
	input  cc3_pkg::out_tag_t         tag_s2,
	input  logic                      out_stall,
	output logic                      take,
	output logic                      out_valid,
	output cc3_pkg::pix_t             pixel_out,
	output logic                      frame_end
);
	import cc3_pkg::*;

	logic        v_s3;
	rsum_t [2:0] rsum_s3;
	pix_t        center_s3;
	out_tag_t    tag_s3;
	logic        out_valid_q;
	pix_t        pixel_q;
	logic        frame_end_q;
	logic        out_free;
	acc_t        acc;

	assign out_free = !out_valid_q || !out_stall;
	assign take     = !v_s3 || out_free;
	assign acc      = acc_t'(rsum_s3[0]) + acc_t'(rsum_s3[1]) + acc_t'(rsum_s3[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (valid_s2 && take) begin
				v_s3 <= 1'b1;
			end else if (out_free) begin
				v_s3 <= 1'b0;
			end
			if (v_s3 && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2 && take) begin
			for (int r = 0; r < 3; r++) begin
				rsum_s3[r] <= rsum_t'($signed(prod_s2[r][0])) + rsum_t'($signed(prod_s2[r][1]))
					+ rsum_t'($signed(prod_s2[r][2]));
			end
			center_s3 <= center_s2;
			tag_s3    <= tag_s2;
		end
		if (v_s3 && out_free) begin
			pixel_q     <= tag_s3.interior ? clamp_acc(acc) : center_s3;
			frame_end_q <= tag_s3.last;
		end
	end

	assign out_valid = out_valid_q;
	assign pixel_out = pixel_q;
	assign frame_end = frame_end_q;

endmodule

[test/conv3x3_clamp_stream_tb.sv]
// Self-checking testbench of the streaming 3x3 convolution with clamped output.
`timescale 1ns / 1ps

module conv3x3_clamp_stream_tb;
	import cc3_pkg::*;

	localparam int LINE_DEPTH = 2048;
	localparam int QUIET_LIMIT = 2000;
	localparam int RANDOM_ITEMS = 950;
	localparam int SETTLE_CYCLES = 10;
	localparam logic CMD_PIXEL = ~CMD_FLUSH;
	localparam krow_t KROW_ALL_MAX = 48'h7FFF_7FFF_7FFF;
	localparam krow_t KROW_ALL_MIN = 48'h8000_8000_8000;

	typedef struct packed {
		pix_t pixel;
		logic last;
	} filtered_t;

	typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_e;

	class filtered_pixel_board;
		geom_t width_reg;
		geom_t height_reg;
		krow_t kernel[3];
		pix_t upper_line[LINE_DEPTH];
		pix_t lower_line[LINE_DEPTH];
		pix_t win[3][3];
		int unsigned in_col;
		int unsigned in_row;
		int unsigned out_pos;
		filtered_t expected_pixels[$];
		int mismatches;
		int checked;
		int frames_done;
		int interior_count;
		int border_count;

		function new();
			width_reg = WIDTH_RST;
			height_reg = HEIGHT_RST;
			kernel[0] = KROW_OUTER_RST;
			kernel[1] = KROW_MIDDLE_RST;
			kernel[2] = KROW_OUTER_RST;
			foreach (upper_line[i]) begin
				upper_line[i] = '0;
				lower_line[i] = '0;
			end
			foreach (win[r, k]) win[r][k] = '0;
			restart_frame();
		endfunction

		function void restart_frame();
			in_col = 0;
			in_row = 0;
			out_pos = 0;
		endfunction

		function int unsigned used_width();
			if (width_reg < 3) return 3;
			if (width_reg > LINE_DEPTH) return LINE_DEPTH;
			return width_reg;
		endfunction

		function int unsigned used_height();
			if (height_reg < 3) return 3;
			return height_reg;
		endfunction

		function void write_register(cfg_idx_t idx, krow_t data);
			case (idx)
				REG_IMAGE_WIDTH: begin
					width_reg = data[GEOM_W-1:0];
					restart_frame();
				end
				REG_IMAGE_HEIGHT: begin
					height_reg = data[GEOM_W-1:0];
					restart_frame();
				end
				REG_KERNEL_TOP: kernel[0] = data;
				REG_KERNEL_MIDDLE: kernel[1] = data;
				REG_KERNEL_BOTTOM: kernel[2] = data;
				default: ;
			endcase
		endfunction

		function void push_pixel(pix_t p, int unsigned w);
			int unsigned col;
			col = in_col % LINE_DEPTH;
			for (int r = 0; r < 3; r++) begin
				win[r][0] = win[r][1];
				win[r][1] = win[r][2];
			end
			win[0][2] = upper_line[col];
			win[1][2] = lower_line[col];
			win[2][2] = p;
			upper_line[col] = lower_line[col];
			lower_line[col] = p;
			in_col++;
			if (in_col >= w) begin
				in_col = 0;
				in_row++;
			end
		endfunction

		function pix_t filter_window();
			longint acc;
			coef_t c;
			acc = 0;
			for (int r = 0; r < 3; r++) begin
				for (int k = 0; k < 3; k++) begin
					c = kernel[r][k*COEF_BITS +: COEF_BITS];
					acc += longint'(win[r][k]) * longint'(c);
				end
			end
			if (acc < 0) return '0;
			acc = acc >>> FRAC_BITS;
			if (acc > 255) return '1;
			return pix_t'(acc);
		endfunction

		function void emit(int unsigned w, int unsigned h);
			int unsigned orow;
			int unsigned ocol;
			bit interior;
			filtered_t item;
			orow = out_pos / w;
			ocol = out_pos % w;
			interior = orow >= 1 && orow + 2 <= h && ocol >= 1 && ocol + 2 <= w;
			item.last = (out_pos + 1 >= w * h);
			item.pixel = interior ? filter_window() : win[1][1];
			if (interior) interior_count++;
			else border_count++;
			expected_pixels.push_back(item);
			if (item.last) restart_frame();
			else out_pos++;
		endfunction

		function void note_input(logic c, pix_t p);
			int unsigned w;
			int unsigned h;
			bit produces;
			w = used_width();
			h = used_height();
			if (in_row >= h) begin
				push_pixel('0, w);
				emit(w, h);
				return;
			end
			if (c == CMD_FLUSH) return;
			produces = in_row >= 2 || (in_row == 1 && in_col >= 1);
			push_pixel(p, w);
			if (produces) emit(w, h);
		endfunction

		function void check_result(pix_t pix, logic fe);
			filtered_t want;
			if (expected_pixels.size() == 0) begin
				$error("unexpected output item: pixel_out %0d, frame_end %0b", pix, fe);
				mismatches++;
				return;
			end
			want = expected_pixels.pop_front();
			if (pix !== want.pixel) begin
				$error("pixel_out: expected %0d, actual %0d", want.pixel, pix);
				mismatches++;
			end
			if (fe !== want.last) begin
				$error("frame_end: expected %0b, actual %0b", want.last, fe);
				mismatches++;
			end
			checked++;
			if (want.last) frames_done++;
		endfunction

		function int pending();
			return expected_pixels.size();
		endfunction

		function void finish_check();
			if (expected_pixels.size() != 0) begin
				$error("%0d expected output items never arrived", expected_pixels.size());
				mismatches++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic cmd = 1'b0;
	pix_t pixel_in = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	pix_t pixel_out;
	logic frame_end;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	cfg_idx_t cfg_index = '0;
	krow_t cfg_data = '0;

	filtered_pixel_board board = new();
	cfg_idx_t kernel_regs[3] = '{REG_KERNEL_TOP, REG_KERNEL_MIDDLE, REG_KERNEL_BOTTOM};
	int burst_left = 0;
	bit gaps_on = 1'b1;
	int items_sent = 0;
	int random_items = 0;
	int reg_writes = 0;
	int quiet_cycles = 0;
	stall_mode_e stall_mode = STALL_NONE;
	int stall_left = 0;
	int stall_tick = 0;

	conv3x3_clamp_stream #(.MAX_WIDTH(LINE_DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.pixel_in(pixel_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pixel_out(pixel_out),
		.frame_end(frame_end),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = stall_mode_e'($urandom_range(0, 3));
			stall_left = $urandom_range(20, 200);
		end
		stall_left--;
		stall_tick++;
		case (stall_mode)
			STALL_NONE: out_stall <= 1'b0;
			STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
			default: out_stall <= (stall_tick % 5 < 2);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) board.check_result(pixel_out, frame_end);
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	task automatic send_item(input logic c, input pix_t p);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = gaps_on ? $urandom_range(0, 6) : 0;
			if (gap > 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		in_valid <= 1'b1;
		cmd <= c;
		pixel_in <= p;
		do @(posedge clk); while (in_stall);
		board.note_input(c, p);
		items_sent++;
	endtask

	task automatic write_reg(input cfg_idx_t idx, input krow_t data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		board.write_register(idx, data);
		reg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic krow_t geom_word(int unsigned v);
		krow_t word;
		word = krow_t'({$urandom(), $urandom()});
		word[GEOM_W-1:0] = GEOM_W'(v);
		return word;
	endfunction

	function automatic krow_t rand_krow();
		krow_t row;
		coef_t c;
		for (int k = 0; k < 3; k++) begin
			case ($urandom_range(0, 3))
				0: c = coef_t'($urandom());
				default: c = coef_t'($urandom_range(0, 1024) - 512);
			endcase
			row[k*COEF_BITS +: COEF_BITS] = c;
		end
		return row;
	endfunction

	function automatic pix_t rand_pixel();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return pix_t'($urandom());
		endcase
	endfunction

	// A stop count of zero feeds a whole frame and its drain; a negative one stops at random.
	task automatic feed_frame(input int stop_at);
		int unsigned w;
		int unsigned h;
		int total;
		int pause_at;
		w = board.used_width();
		h = board.used_height();
		total = w * h + w + 1;
		if (stop_at == 0) stop_at = total;
		else if (stop_at < 0) stop_at = $urandom_range(1, total - 1);
		pause_at = ($urandom_range(0, 3) == 0) ? $urandom_range(1, stop_at) : -1;
		gaps_on = ($urandom_range(0, 3) != 0);
		for (int i = 0; i < stop_at; i++) begin
			if (i == pause_at) begin
				settle();
				write_reg(kernel_regs[$urandom_range(0, 2)], rand_krow());
			end
			if (i < w * h) begin
				if ($urandom_range(0, 11) == 0) send_item(CMD_FLUSH, rand_pixel());
				send_item(CMD_PIXEL, rand_pixel());
			end else if ($urandom_range(0, 3) == 0) begin
				send_item(CMD_PIXEL, rand_pixel());
			end else begin
				send_item(CMD_FLUSH, rand_pixel());
			end
			random_items++;
		end
		settle();
	endtask

	initial begin
		pix_t frame_a[9];
		pix_t frame_b[12];
		bit broken;

		frame_a = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd255};
		frame_b = '{8'd255, 8'd255, 8'd0, 8'd0, 8'd17, 8'd200, 8'd3, 8'd90,
			8'd0, 8'd0, 8'd255, 8'd255};

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Smallest frame under the reset Sobel kernel, with an idle flush and a pixel in the drain.
		write_reg(REG_IMAGE_WIDTH, geom_word(3));
		write_reg(REG_IMAGE_HEIGHT, geom_word(3));
		send_item(CMD_FLUSH, 8'hA5);
		foreach (frame_a[i]) send_item(CMD_PIXEL, frame_a[i]);
		send_item(CMD_FLUSH, '0);
		send_item(CMD_PIXEL, '1);
		send_item(CMD_FLUSH, '0);
		send_item(CMD_FLUSH, '0);
		settle();

		// Extreme coefficients: one interior pixel saturates high, the other goes negative.
		write_reg(REG_IMAGE_WIDTH, geom_word(4));
		write_reg(REG_KERNEL_TOP, KROW_ALL_MAX);
		write_reg(REG_KERNEL_MIDDLE, '0);
		write_reg(REG_KERNEL_BOTTOM, KROW_ALL_MIN);
		foreach (frame_b[i]) send_item(CMD_PIXEL, frame_b[i]);
		repeat (5) send_item(CMD_FLUSH, '0);
		settle();

		// Tallest and widest geometry, each in a frame cut short.
		write_reg(REG_IMAGE_WIDTH, geom_word(1));
		write_reg(REG_IMAGE_HEIGHT, geom_word(4095));
		write_reg(REG_KERNEL_MIDDLE, rand_krow());
		feed_frame(3 * 16 + $urandom_range(1, 20));
		write_reg(REG_IMAGE_HEIGHT, geom_word(0));
		write_reg(REG_IMAGE_WIDTH, geom_word(4095));
		feed_frame($urandom_range(40, 80));
		broken = 1'b1;
		random_items = 0;

		while (random_items < RANDOM_ITEMS) begin
			if (broken || $urandom_range(0, 2) == 0) begin
				write_reg(REG_IMAGE_WIDTH, geom_word(($urandom_range(0, 9) == 0) ?
					$urandom_range(0, 2) : $urandom_range(3, 10)));
				if ($urandom_range(0, 1) == 0) begin
					write_reg(REG_IMAGE_HEIGHT, geom_word(($urandom_range(0, 9) == 0) ?
						$urandom_range(0, 2) : $urandom_range(3, 7)));
				end
			end
			if ($urandom_range(0, 2) == 0) write_reg(kernel_regs[$urandom_range(0, 2)], rand_krow());
			if ($urandom_range(0, 19) == 0) begin
				write_reg(REG_KERNEL_BOTTOM + cfg_idx_t'($urandom_range(1, 3)),
					krow_t'({$urandom(), $urandom()}));
			end
			broken = ($urandom_range(0, 5) == 0);
			feed_frame(broken ? -1 : 0);
		end

		settle();
		board.finish_check();
		$display("Covered %0d frames: %0d filtered and %0d border pixels checked.",
			board.frames_done, board.interior_count, board.border_count);
		$display("%0d input items and %0d register writes were sent.", items_sent, reg_writes);
		if (board.mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
